// File: design/pbe_pkg.sv
`default_nettype none
package pbe_pkg;

   localparam int unsigned POW_TABLE_BITS = 8;
   localparam int unsigned TAB_SIZE = 1 << POW_TABLE_BITS;
   localparam int unsigned LATENCY = 13;

   // 1/pi in Q0.32.
   localparam logic [30:0] INVPI_Q32 = 31'd1367130551;

   localparam logic [2:0] REG_DIFFUSE_RED    = 3'd0;
   localparam logic [2:0] REG_DIFFUSE_GREEN  = 3'd1;
   localparam logic [2:0] REG_DIFFUSE_BLUE   = 3'd2;
   localparam logic [2:0] REG_SPECULAR_RED   = 3'd3;
   localparam logic [2:0] REG_SPECULAR_GREEN = 3'd4;
   localparam logic [2:0] REG_SPECULAR_BLUE  = 3'd5;
   localparam logic [2:0] REG_SHININESS      = 3'd6;

   localparam logic [15:0] SHININESS_RESET = 16'd2560;

   typedef logic [15:0] log_tab_type [TAB_SIZE];
   typedef logic [31:0] exp_tab_type [TAB_SIZE];

   function automatic longint unsigned isqrt64(longint unsigned x_arg);
      longint unsigned x;
      longint unsigned r;
      longint unsigned b;
      x = x_arg;
      r = 0;
      b = 64'd1 << 62;
      for (int s = 0; s < 32; s++) begin
         if (b > x) begin
            b = b >> 2;
         end
      end
      for (int s = 0; s < 32; s++) begin
         if (b != 0) begin
            if (x >= r + b) begin
               x = x - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
      end
      return r;
   endfunction

   function automatic log_tab_type make_log_tab();
      log_tab_type tab;
      longint unsigned m;
      logic [15:0] y;
      for (int i = 0; i < TAB_SIZE; i++) begin
         m = (longint'(TAB_SIZE) + longint'(i)) << (30 - POW_TABLE_BITS);
         y = '0;
         for (int k = 15; k >= 0; k--) begin
            m = (m * m) >> 30;
            if (m >= (64'd1 << 31)) begin
               m = m >> 1;
               y[k] = 1'b1;
            end
         end
         tab[i] = y;
      end
      return tab;
   endfunction

   function automatic exp_tab_type make_exp_tab();
      exp_tab_type tab;
      longint unsigned r;
      longint unsigned root;
      for (int j = 0; j < TAB_SIZE; j++) begin
         r = 64'd1 << 30;
         root = 64'd2 << 30;
         for (int k = 1; k <= POW_TABLE_BITS; k++) begin
            root = isqrt64(root << 30);
            if (((j >> (POW_TABLE_BITS - k)) & 1) != 0) begin
               r = (r * root) >> 30;
            end
         end
         tab[j] = 32'(r);
      end
      return tab;
   endfunction

   localparam log_tab_type LOG_TAB = make_log_tab();
   localparam exp_tab_type EXP_TAB = make_exp_tab();

   typedef struct packed {
      logic        valid;
      logic [16:0] alpha;
   } power_in_type;

   typedef struct packed {
      logic        valid;
      logic [17:0] power;
   } power_out_type;

endpackage
`default_nettype wire

// File: design/pbe_power.sv
`default_nettype none
module pbe_power (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   enable,
   input  wire logic [15:0]            shininess,
   input  wire pbe_pkg::power_in_type  power_in,
   output pbe_pkg::power_out_type      power_out
);

   localparam int unsigned B = pbe_pkg::POW_TABLE_BITS;

   // Stage A: leading one, normalization and log lookup.
   logic          va_ff;
   logic          zero_a_ff;
   logic [20:0]   lg_ff;
   logic [4:0]    lead;
   logic [16:0]   norm;
   logic [B-1:0]  idx;
   logic [20:0]   lg_in;

   always_comb begin
      lead = '0;
      for (int i = 0; i < 17; i++) begin
         if (power_in.alpha[i]) begin
            lead = 5'(i);
         end
      end
      norm = power_in.alpha << (5'd16 - lead);
      idx = norm[15 -: B];
      lg_in = {5'(5'd16 - lead), 16'd0} - 21'(pbe_pkg::LOG_TAB[idx]);
   end

   // Stage B: exponent times log.
   logic          vb_ff;
   logic          zero_b_ff;
   logic [28:0]   e_ff;
   logic [36:0]   prod;
   logic [28:0]   e_in;

   always_comb begin
      prod = 37'(lg_ff) * 37'(shininess);
      e_in = 29'((prod + 37'd128) >> 8);
   end

   // Stage C: split into integer and fraction, exp lookup.
   logic          vc_ff;
   logic          zero_c_ff;
   logic [31:0]   ent_ff;
   logic [14:0]   t_ff;
   logic [13:0]   k;
   logic [16:0]   comp;
   logic [B-1:0]  jidx;

   always_comb begin
      comp = 17'h10000 - 17'(e_ff[15:0]);
      if (e_ff[15:0] == 16'd0) begin
         k = 14'(e_ff[28:16]);
         jidx = '0;
      end else begin
         k = 14'(e_ff[28:16]) + 14'd1;
         jidx = B'(comp >> (16 - B));
      end
   end

   // Stage D: scale by 2^-(14+k) with rounding.
   logic          vd_ff;
   logic [17:0]   pw_ff;
   logic [17:0]   pw_in;
   logic [40:0]   sum;

   always_comb begin
      sum = 41'(ent_ff) + (41'd1 << (t_ff - 15'd1));
      if (shininess == 16'd0) begin
         pw_in = 18'h10000;
      end else if (zero_c_ff || (t_ff > 15'd40)) begin
         pw_in = '0;
      end else begin
         pw_in = 18'(sum >> t_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
         vd_ff <= 1'b0;
      end else if (enable) begin
         va_ff <= power_in.valid;
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
         vd_ff <= vc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         zero_a_ff <= (power_in.alpha == 17'd0);
         lg_ff     <= lg_in;
         zero_b_ff <= zero_a_ff;
         e_ff      <= e_in;
         zero_c_ff <= zero_b_ff;
         ent_ff    <= pbe_pkg::EXP_TAB[jidx];
         t_ff      <= 15'(k) + 15'd14;
         pw_ff     <= pw_in;
      end
   end

   assign power_out.valid = vd_ff;
   assign power_out.power = pw_ff;

endmodule
`default_nettype wire

// File: design/phong_brdf_evaluate.sv
`default_nettype none
// Normalized modified Phong BRDF evaluation.
// Input channel (req_): one transaction carries the outgoing direction, the
// incoming direction and the surface normal, each a signed Q2.14 vector.
// Result channel (rsp_): one transaction per input transaction, three unsigned
// Q8.16 channel values, saturated at full scale, in input order.
// Configuration (csr_): seven 16-bit registers, which the user must write by
// index only while the block is idle; the block does not enforce it.
// csr_ready is always high; unknown indexes are ignored. The datapath is a
// 13-stage pipeline (dot products, reflection, alpha, log and exp tables,
// channel multiplies) taking one transaction every cycle while not stalled.
// When the receiver stalls a valid result, the whole pipeline holds and
// req_stall is raised in the same cycle; no transaction is lost or repeated.
// Reset clears all valid bits and returns the registers to their defaults
// (reflectances zero, shininess 10.0).
module phong_brdf_evaluate (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic signed [15:0] req_out_x,
   input  wire logic signed [15:0] req_out_y,
   input  wire logic signed [15:0] req_out_z,
   input  wire logic signed [15:0] req_in_x,
   input  wire logic signed [15:0] req_in_y,
   input  wire logic signed [15:0] req_in_z,
   input  wire logic signed [15:0] req_normal_x,
   input  wire logic signed [15:0] req_normal_y,
   input  wire logic signed [15:0] req_normal_z,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [23:0]             rsp_value_red,
   output logic [23:0]             rsp_value_green,
   output logic [23:0]             rsp_value_blue,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [2:0]         csr_index,
   input  wire logic [15:0]        csr_data
);

   logic [15:0] diffuse_ff [3];
   logic [15:0] specular_ff [3];
   logic [15:0] shininess_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         diffuse_ff[0]  <= '0;
         diffuse_ff[1]  <= '0;
         diffuse_ff[2]  <= '0;
         specular_ff[0] <= '0;
         specular_ff[1] <= '0;
         specular_ff[2] <= '0;
         shininess_ff   <= pbe_pkg::SHININESS_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            pbe_pkg::REG_DIFFUSE_RED:    diffuse_ff[0]  <= csr_data;
            pbe_pkg::REG_DIFFUSE_GREEN:  diffuse_ff[1]  <= csr_data;
            pbe_pkg::REG_DIFFUSE_BLUE:   diffuse_ff[2]  <= csr_data;
            pbe_pkg::REG_SPECULAR_RED:   specular_ff[0] <= csr_data;
            pbe_pkg::REG_SPECULAR_GREEN: specular_ff[1] <= csr_data;
            pbe_pkg::REG_SPECULAR_BLUE:  specular_ff[2] <= csr_data;
            pbe_pkg::REG_SHININESS:      shininess_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   logic enable;
   logic rsp_valid_ff;

   assign enable    = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !enable;
   assign rsp_valid = rsp_valid_ff;

   logic signed [15:0] wo [3];
   logic signed [15:0] wi [3];
   logic signed [15:0] nv [3];

   assign wo[0] = req_out_x;
   assign wo[1] = req_out_y;
   assign wo[2] = req_out_z;
   assign wi[0] = req_in_x;
   assign wi[1] = req_in_y;
   assign wi[2] = req_in_z;
   assign nv[0] = req_normal_x;
   assign nv[1] = req_normal_y;
   assign nv[2] = req_normal_z;

   // Valid bits of the stages before the power unit.
   logic [5:0] v_ff;
   // Valid bits of the stages after it.
   logic [1:0] w_ff;

   logic signed [31:0] p1_ff [3];
   logic signed [15:0] wo1_ff [3];
   logic signed [15:0] wi1_ff [3];
   logic signed [15:0] n1_ff [3];
   logic signed [32:0] dn2_ff;
   logic signed [15:0] wo2_ff [3];
   logic signed [15:0] wi2_ff [3];
   logic signed [15:0] n2_ff [3];
   logic signed [49:0] m3_ff [3];
   logic signed [15:0] wo3_ff [3];
   logic signed [15:0] wi3_ff [3];
   logic signed [36:0] refl4_ff [3];
   logic signed [15:0] wi4_ff [3];
   logic signed [52:0] q5_ff [3];
   logic [16:0]        alpha6_ff;

   logic signed [32:0] dn2_in;
   logic signed [54:0] ad;
   logic [54:0]        mag;
   logic [29:0]        alpha_raw;
   logic [16:0]        alpha6_in;

   always_comb begin
      dn2_in = 33'(p1_ff[0]) + 33'(p1_ff[1]) + 33'(p1_ff[2]);
      ad = 55'(q5_ff[0]) + 55'(q5_ff[1]) + 55'(q5_ff[2]);
      mag = ad[54] ? 55'(-ad) : 55'(ad);
      alpha_raw = 30'((mag + (55'd1 << 25)) >> 26);
      alpha6_in = (alpha_raw > 30'h10000) ? 17'h10000 : 17'(alpha_raw);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int i = 0; i < 3; i++) begin
            p1_ff[i]  <= wo[i] * nv[i];
            wo1_ff[i] <= wo[i];
            wi1_ff[i] <= wi[i];
            n1_ff[i]  <= nv[i];
            wo2_ff[i] <= wo1_ff[i];
            wi2_ff[i] <= wi1_ff[i];
            n2_ff[i]  <= n1_ff[i];
            m3_ff[i]  <= (50'(dn2_ff) * 50'(n2_ff[i])) <<< 1;
            wo3_ff[i] <= wo2_ff[i];
            wi3_ff[i] <= wi2_ff[i];
            refl4_ff[i] <= 37'((m3_ff[i] + 50'sd8192) >>> 14) - (37'(wo3_ff[i]) <<< 14);
            wi4_ff[i] <= wi3_ff[i];
            q5_ff[i]  <= 53'(wi4_ff[i]) * 53'(refl4_ff[i]);
         end
         dn2_ff    <= dn2_in;
         alpha6_ff <= alpha6_in;
      end
   end

   pbe_pkg::power_in_type  power_in;
   pbe_pkg::power_out_type power_out;

   assign power_in.valid = v_ff[5];
   assign power_in.alpha = alpha6_ff;

   pbe_power u_power (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .shininess (shininess_ff),
      .power_in  (power_in),
      .power_out (power_out)
   );

   // Per-channel terms; sp1_ff and dt_ff depend on configuration only.
   logic [32:0]  sp1_ff [3];
   logic [46:0]  dt_ff [3];
   logic [50:0]  sp_ff [3];
   logic [67:0]  st_ff [3];
   logic [23:0]  val_ff [3];
   logic [35:0]  sr [3];
   logic [68:0]  tot [3];
   logic [27:0]  vsum [3];
   logic [23:0]  val_in [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sr[i] = 36'((52'(sp_ff[i]) + 52'd32768) >> 16);
         tot[i] = (69'(dt_ff[i]) << 9) + 69'(st_ff[i]) + (69'd1 << 40);
         vsum[i] = 28'(tot[i] >> 41);
         val_in[i] = (vsum[i] > 28'hFFFFFF) ? 24'hFFFFFF : 24'(vsum[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int i = 0; i < 3; i++) begin
            sp1_ff[i] <= 33'(specular_ff[i]) * 33'(17'(shininess_ff) + 17'd512);
            dt_ff[i]  <= 47'(diffuse_ff[i]) * 47'(pbe_pkg::INVPI_Q32);
            sp_ff[i]  <= 51'(sp1_ff[i]) * 51'(power_out.power);
            st_ff[i]  <= 68'(sr[i]) * 68'(pbe_pkg::INVPI_Q32);
            val_ff[i] <= val_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff         <= '0;
         w_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (enable) begin
         v_ff         <= {v_ff[4:0], req_valid};
         w_ff         <= {w_ff[0], power_out.valid};
         rsp_valid_ff <= w_ff[1];
      end
   end

   assign rsp_value_red   = val_ff[0];
   assign rsp_value_green = val_ff[1];
   assign rsp_value_blue  = val_ff[2];

`ifndef SYNTHESIS
   // The clamped alpha and the resulting power never exceed one.
   a_alpha_max: assert property (@(posedge clock) disable iff (reset)
      v_ff[5] |-> (alpha6_ff <= 17'h10000))
      else $error("alpha above one entered the power unit");

   a_power_max: assert property (@(posedge clock) disable iff (reset)
      power_out.valid |-> (power_out.power <= 18'h10000))
      else $error("power above one left the power unit");

   // The red channel with no reflectance at all gives zero.
   a_black_red: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (diffuse_ff[0] == 16'd0) && (specular_ff[0] == 16'd0)
         |-> (rsp_value_red == 24'd0))
      else $error("nonzero red result with zero reflectance");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");
`endif

endmodule
`default_nettype wire
